/* src/nor_flash_array_model_defines.svh */
// Assertion macros shared by the flash array model RTL.
`ifndef NOR_FLASH_ARRAY_MODEL_DEFINES_SVH
`define NOR_FLASH_ARRAY_MODEL_DEFINES_SVH

// Concurrent check on clk, off while arst_n is low.
`define NFA_ASSERT(label, prop, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) prop) else $error(msg);

// Same-cycle implication built on the one above.
`define NFA_ASSERT_IMP(label, ante, cons, msg) \
	`NFA_ASSERT(label, (ante) |-> (cons), msg)

`endif

/* src/nfa_pkg.sv */
// Types and constants for the NOR flash array model.
package nfa_pkg;

	typedef enum logic [1:0] {
		CMD_READ   = 2'd0,
		CMD_PROG   = 2'd1,
		CMD_ERASE  = 2'd2,
		CMD_STATUS = 2'd3
	} cmd_t;

	typedef enum logic [1:0] {
		CODE_OK    = 2'd0,
		CODE_WP    = 2'd1,
		CODE_RANGE = 2'd2
	} code_t;

	typedef enum logic [1:0] {
		ST_CLEAR,
		ST_IDLE,
		ST_ACCESS,
		ST_ERASE
	} state_t;

	localparam logic [7:0] ERASED_BYTE = 8'hFF;
	localparam logic [1:0] STAT_BUSY   = 2'b01;
	localparam logic [1:0] STAT_WP     = 2'b10;

	// Word index of the write-protect register on the config port.
	localparam logic REG_WP = 1'b0;

endpackage

/* src/nfa_cfg.sv */
// Configuration register file: write-protect bit behind the APB port.
module nfa_cfg
	import nfa_pkg::*;
(
	input  logic        clk,
	input  logic        arst_n,
	input  logic        psel,
	input  logic        penable,
	input  logic        pwrite,
	input  logic [2:0]  paddr,
	input  logic [31:0] pwdata,
	output logic [31:0] prdata,
	output logic        write_protect
);

	logic wp_q;
	logic wr_en;

	assign wr_en = psel && penable && pwrite && (paddr[2] == REG_WP);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wp_q <= 1'b0;
		end else if (wr_en) begin
			wp_q <= pwdata[0];
		end
	end

	assign prdata        = (paddr[2] == REG_WP) ? {31'b0, wp_q} : 32'b0;
	assign write_protect = wp_q;

endmodule

/* src/nor_flash_array_model.sv */
// Top level of the NOR flash array model: byte store, command sequencer, APB config.
//
// Usage
//  - Command channel: present cmd, start_addr, offset and write_data with start;
//    the command transfer happens at a rising edge with start high and busy low.
//  - Result channel: done is high for exactly one cycle with status_code,
//    read_data, data_valid and status_byte; the receiver cannot stall it, so
//    the result must be taken in that cycle.
//  - Config: APB port, write_protect at byte address 0 (bit 0). pready is tied
//    high; writes complete in the access cycle and are taken even while busy.
// Command sequencing
//  - Byte read and byte program: the store is a synchronous RAM with one read
//    port and one write port. The command cycle issues the read, the next
//    cycle returns the byte (and writes back old AND new for a program), and
//    done follows in the cycle after. busy is high for one cycle and blocks start.
//  - Status reads and refused or out-of-range commands: done in the cycle after
//    the transfer, busy stays low, so one command per cycle.
//  - Sector erase: one byte written per cycle, SECTOR_BYTES bytes (fewer for
//    a last sector clipped at the end of the array), done right after.
// Reset
//  - arst_n clears control state, then a clearing pass writes 0xFF to all
//    FLASH_BYTES entries, one per cycle, with busy high.
module nor_flash_array_model
	import nfa_pkg::*;
#(
	parameter int FLASH_BYTES  = 65536,
	parameter int SECTOR_BYTES = 4096
) (
	input  logic        clk,
	input  logic        arst_n,
	// command channel
	input  logic        start,
	output logic        busy,
	input  logic [1:0]  cmd,
	input  logic [23:0] start_addr,
	input  logic [23:0] offset,
	input  logic [7:0]  write_data,
	// result channel
	output logic        done,
	output logic [1:0]  status_code,
	output logic [7:0]  read_data,
	output logic        data_valid,
	output logic [1:0]  status_byte,
	// configuration port
	input  logic        psel,
	input  logic        penable,
	input  logic        pwrite,
	input  logic [2:0]  paddr,
	input  logic [31:0] pwdata,
	output logic [31:0] prdata,
	output logic        pready
);

`include "nor_flash_array_model_defines.svh"

	// AW: address bits of the store; SW: offset bits within a sector (power of two)
	localparam int              AW        = $clog2(FLASH_BYTES);
	localparam int              SW        = $clog2(SECTOR_BYTES);
	localparam logic [24:0]     FLASH_LIM = 25'(FLASH_BYTES);
	localparam logic [AW-1:0]   LAST_ADDR = AW'(FLASH_BYTES - 1);
	localparam logic [23:0]     SECT_MASK = 24'(SECTOR_BYTES - 1);

	logic write_protect;

	nfa_cfg u_cfg (
		.clk          (clk),
		.arst_n       (arst_n),
		.psel         (psel),
		.penable      (penable),
		.pwrite       (pwrite),
		.paddr        (paddr),
		.pwdata       (pwdata),
		.prdata       (prdata),
		.write_protect(write_protect)
	);

	assign pready = 1'b1;

	// ---------------------------------------------------------------- store
	logic [7:0]    mem [FLASH_BYTES];
	logic [7:0]    mem_rdata_q;
	logic          mem_we;
	logic [AW-1:0] mem_waddr;
	logic [7:0]    mem_wdata;

	// ---------------------------------------------------------------- control
	state_t        state_q, state_d;
	logic [AW-1:0] ptr_q, ptr_d;
	cmd_t          cmd_q;
	logic [AW-1:0] addr_q;
	logic [7:0]    wdata_q;

	logic          accept;
	logic [24:0]   pos;
	logic          start_ok;
	logic          pos_ok;
	logic [AW-1:0] sect_base;
	logic [24:0]   ptr_ext;
	logic          sect_end;
	logic          ptr_last;
	logic [1:0]    sbyte;

	// result register inputs
	logic          res_ld;
	code_t         res_code;
	logic [7:0]    res_rdata;
	logic          res_valid;
	logic [1:0]    res_sbyte;

	// result registers
	logic          done_q;
	code_t         code_q;
	logic [7:0]    rdata_q;
	logic          valid_q;
	logic [1:0]    sbyte_q;

	assign busy      = (state_q != ST_IDLE);
	assign accept    = start && !busy;
	assign pos       = {1'b0, start_addr} + {1'b0, offset};
	assign start_ok  = ({1'b0, start_addr} < FLASH_LIM);
	assign pos_ok    = (pos < FLASH_LIM);
	assign sect_base = AW'(start_addr & ~SECT_MASK);
	assign ptr_ext   = 25'(ptr_q);
	assign sect_end  = &ptr_ext[SW-1:0];
	assign ptr_last  = (ptr_q == LAST_ADDR);
	assign sbyte     = (write_protect ? STAT_WP : 2'b00) & ~STAT_BUSY;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_CLEAR;
			ptr_q   <= '0;
		end else begin
			state_q <= state_d;
			ptr_q   <= ptr_d;
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			cmd_q   <= cmd_t'(cmd);
			addr_q  <= pos[AW-1:0];
			wdata_q <= write_data;
		end
	end

	always_comb begin
		state_d   = state_q;
		ptr_d     = ptr_q;
		mem_we    = 1'b0;
		mem_waddr = ptr_q;
		mem_wdata = ERASED_BYTE;
		res_ld    = 1'b0;
		res_code  = CODE_OK;
		res_rdata = 8'h00;
		res_valid = 1'b0;
		res_sbyte = 2'b00;
		unique case (state_q)
			ST_CLEAR: begin
				mem_we = 1'b1;
				if (ptr_last) begin
					state_d = ST_IDLE;
				end else begin
					ptr_d = ptr_q + AW'(1);
				end
			end
			ST_IDLE: begin
				if (accept) begin
					unique case (cmd_t'(cmd))
						CMD_READ: begin
							if (!start_ok) begin
								res_ld   = 1'b1;
								res_code = CODE_RANGE;
							end else if (pos_ok) begin
								state_d = ST_ACCESS;
							end else begin
								res_ld = 1'b1;
							end
						end
						CMD_PROG: begin
							if (write_protect) begin
								res_ld   = 1'b1;
								res_code = CODE_WP;
							end else if (!start_ok) begin
								res_ld   = 1'b1;
								res_code = CODE_RANGE;
							end else if (pos_ok) begin
								state_d = ST_ACCESS;
							end else begin
								res_ld = 1'b1;   // past the end: dropped
							end
						end
						CMD_ERASE: begin
							if (write_protect) begin
								res_ld   = 1'b1;
								res_code = CODE_WP;
							end else if (!start_ok) begin
								res_ld   = 1'b1;
								res_code = CODE_RANGE;
							end else begin
								state_d = ST_ERASE;
								ptr_d   = sect_base;
							end
						end
						CMD_STATUS: begin
							res_ld    = 1'b1;
							res_sbyte = sbyte;
						end
					endcase
				end
			end
			ST_ACCESS: begin
				res_ld  = 1'b1;
				state_d = ST_IDLE;
				if (cmd_q == CMD_PROG) begin
					mem_we    = 1'b1;
					mem_waddr = addr_q;
					mem_wdata = mem_rdata_q & wdata_q;
				end else begin
					res_rdata = mem_rdata_q;
					res_valid = 1'b1;
				end
			end
			ST_ERASE: begin
				mem_we = 1'b1;
				if (ptr_last || sect_end) begin
					res_ld  = 1'b1;
					state_d = ST_IDLE;
				end else begin
					ptr_d = ptr_q + AW'(1);
				end
			end
		endcase
	end

	// store: one write port, one registered read port
	always_ff @(posedge clk) begin
		if (mem_we) begin
			mem[mem_waddr] <= mem_wdata;
		end
		if (accept) begin
			mem_rdata_q <= mem[pos[AW-1:0]];
		end
	end

	// result registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			done_q <= 1'b0;
		end else begin
			done_q <= res_ld;
		end
	end

	always_ff @(posedge clk) begin
		if (res_ld) begin
			code_q  <= res_code;
			rdata_q <= res_rdata;
			valid_q <= res_valid;
			sbyte_q <= res_sbyte;
		end
	end

	assign done        = done_q;
	assign status_code = code_q;
	assign read_data   = rdata_q;
	assign data_valid  = valid_q;
	assign status_byte = sbyte_q;

	// ---------------------------------------------------------------- checks
	`NFA_ASSERT(a_cmd_answered, (accept) |=> (busy || done), "command transfer left unanswered")
	`NFA_ASSERT_IMP(a_sweep_writes, (state_q == ST_ERASE || state_q == ST_CLEAR), (mem_we && mem_wdata == ERASED_BYTE), "sweep cycle without erase write")
	`NFA_ASSERT_IMP(a_prog_writeback, (state_q == ST_ACCESS && cmd_q == CMD_PROG), (mem_we && mem_waddr == addr_q), "program write-back missing")
	`NFA_ASSERT_IMP(a_valid_ok, (done && data_valid), (status_code == CODE_OK), "valid data with error code")

endmodule
